@@ hdl/dedup_packet_fifo_with_range_count_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dedup packet FIFO
// Shared wrappers for concurrent checks clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_UNIT_MACROS_SVH
`define DEDUP_PACKET_FIFO_WITH_RANGE_COUNT_UNIT_MACROS_SVH

// check a property outside of reset
`define DPFRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define DPFRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dpfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// dpfrc_pkg
// Types, codes and sizes shared by the dedup packet FIFO modules.
// ----------------------------------------------------------------------------
package dpfrc_pkg;

   // default number of stored entries
   localparam int CAPACITY_DEFAULT = 64;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 16;
   localparam int TIME_W   = 30;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 7;
   localparam int COUNT_W  = 7;

   // largest limit the register can express
   localparam int LIMIT_MAX = 127;

   // reset value of the limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   // command codes
   localparam cmd_type CMD_ADD   = 2'd0;
   localparam cmd_type CMD_FWD   = 2'd1;
   localparam cmd_type CMD_COUNT = 2'd2;

   // status codes
   localparam status_type ST_ADDED = 3'd0;
   localparam status_type ST_DUP   = 3'd1;
   localparam status_type ST_FWD   = 3'd2;
   localparam status_type ST_EMPTY = 3'd3;
   localparam status_type ST_COUNT = 3'd4;

   // one stored packet
   typedef struct packed {
      logic [ID_W-1:0]   src;
      logic [ID_W-1:0]   dst;
      logic [TIME_W-1:0] ts;
   } entry_type;

   // search key of the item under work
   typedef struct packed {
      entry_type         pkt;
      logic [TIME_W-1:0] t_lo;
      logic [TIME_W-1:0] t_hi;
   } key_type;

   // compare unit verdicts
   typedef struct packed {
      logic dup_hit;
      logic range_hit;
   } hit_type;

endpackage

@@ hdl/dpfrc_store.sv @@
// ----------------------------------------------------------------------------
// dpfrc_store
// Packet entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dpfrc_store #(
   parameter int DEPTH = dpfrc_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  dpfrc_pkg::entry_type        wr_data,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output dpfrc_pkg::entry_type        rd_data
);

   dpfrc_pkg::entry_type mem_ff [DEPTH];
   dpfrc_pkg::entry_type rd_data_ff;

   // write and read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dpfrc_cmp.sv @@
// ----------------------------------------------------------------------------
// dpfrc_cmp
// Shared compare unit: checks one stored entry against the current key.
// ----------------------------------------------------------------------------
module dpfrc_cmp (
   input  dpfrc_pkg::entry_type entry,
   input  dpfrc_pkg::key_type   key,
   output dpfrc_pkg::hit_type   hit
);

   logic dst_eq;

   assign dst_eq = (entry.dst == key.pkt.dst);

   // exact triple match for the duplicate check
   assign hit.dup_hit = dst_eq && (entry.src == key.pkt.src) && (entry.ts == key.pkt.ts);

   // destination match with timestamp inside the inclusive window
   assign hit.range_hit = dst_eq && (entry.ts >= key.t_lo) && (entry.ts <= key.t_hi);

endmodule

@@ hdl/dedup_packet_fifo_with_range_count_unit.sv @@
// Add and count read every held entry, one per cycle, and compare it with the item;
// a count or refused add then answers, an appended add first drops and writes.
// Forward reads and pops the oldest entry; empty forward and unused command go straight to the answer.
// The next item is taken in the cycle after the answer is loaded; a finished item holds
// while the previous answer still waits in the output register.
// Synchronous active-high reset empties the queue and sets the limit to 64.
// ----------------------------------------------------------------------------
// dedup_packet_fifo_with_range_count_unit
// Bounded packet FIFO with duplicate filter and destination/time range count.
// ----------------------------------------------------------------------------
`include "dedup_packet_fifo_with_range_count_unit_macros.svh"

module dedup_packet_fifo_with_range_count_unit #(
   parameter int CAPACITY = dpfrc_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dpfrc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [dpfrc_pkg::ID_W-1:0]        req_source,
   input  logic [dpfrc_pkg::ID_W-1:0]        req_destination,
   input  logic [dpfrc_pkg::TIME_W-1:0]      req_timestamp,
   input  logic [dpfrc_pkg::TIME_W-1:0]      req_start_time,
   input  logic [dpfrc_pkg::TIME_W-1:0]      req_end_time,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dpfrc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dpfrc_pkg::ID_W-1:0]        rsp_out_source,
   output logic [dpfrc_pkg::ID_W-1:0]        rsp_out_destination,
   output logic [dpfrc_pkg::TIME_W-1:0]      rsp_out_timestamp,
   output logic [dpfrc_pkg::COUNT_W-1:0]     rsp_match_count,

   input  logic                              csr_wr_en,
   input  logic [dpfrc_pkg::LIMIT_W-1:0]     csr_wr_data
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int LIM_MAX = (CAPACITY < dpfrc_pkg::LIMIT_MAX) ? CAPACITY
                                                              : dpfrc_pkg::LIMIT_MAX;
   localparam int LEVEL_W = $clog2(LIM_MAX + 1);
   localparam int SUM_W   = ((IDX_W > LEVEL_W) ? IDX_W : LEVEL_W) + 1;

   typedef enum logic [2:0] {
      IDLE, SCAN, DROP, WRITE, FETCH, FDATA, DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [dpfrc_pkg::LIMIT_W-1:0]     limit_ff;
   logic [IDX_W-1:0]                  head_ff, head_in;
   logic [LEVEL_W-1:0]                fill_ff, fill_in;
   logic [IDX_W-1:0]                  ptr_ff, ptr_in;
   logic [LEVEL_W-1:0]                idx_ff, idx_in;
   logic [LEVEL_W-1:0]                count_ff, count_in;
   logic                              pend_ff, pend_in;
   logic                              dup_ff, dup_in;
   dpfrc_pkg::cmd_type                cmd_ff, cmd_in;
   dpfrc_pkg::key_type                key_ff, key_in;
   dpfrc_pkg::status_type             res_status_ff, res_status_in;
   dpfrc_pkg::entry_type              res_entry_ff, res_entry_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   dpfrc_pkg::status_type             rsp_status_ff, rsp_status_in;
   dpfrc_pkg::entry_type              rsp_entry_ff, rsp_entry_in;
   logic [dpfrc_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                              mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]                  mem_wr_addr, mem_rd_addr;
   dpfrc_pkg::entry_type              mem_rd_data;
   dpfrc_pkg::hit_type                hit;

   logic                              req_take;
   logic [dpfrc_pkg::LIMIT_W-1:0]     lim_eff, fill_ext, drop_n;
   logic [SUM_W-1:0]                  ma_sum;
   logic [IDX_W-1:0]                  ma_res;
   logic [IDX_W-1:0]                  ptr_next, head_next;

   // entry memory and shared compare unit
   dpfrc_store #(.DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (key_ff.pkt),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   dpfrc_cmp u_cmp (
      .entry (mem_rd_data),
      .key   (key_ff),
      .hit   (hit)
   );

   assign req_stall = (state_ff != IDLE);
   assign req_take  = req_valid && !req_stall;

   // clamp the limit to 1..min(capacity, 127)
   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = 7'd1;
      end else if (limit_ff > 7'(LIM_MAX)) begin
         lim_eff = 7'(LIM_MAX);
      end else begin
         lim_eff = limit_ff;
      end
   end

   assign fill_ext = 7'(fill_ff);
   assign drop_n   = fill_ext - lim_eff + 7'd1;

   // shared modulo adder: head plus drop count, or head plus fill level
   always_comb begin
      if (state_ff == DROP) begin
         ma_sum = SUM_W'(head_ff) + SUM_W'(drop_n);
      end else begin
         ma_sum = SUM_W'(head_ff) + SUM_W'(fill_ff);
      end
      if (ma_sum >= SUM_W'(CAPACITY)) begin
         ma_res = IDX_W'(ma_sum - SUM_W'(CAPACITY));
      end else begin
         ma_res = IDX_W'(ma_sum);
      end
   end

   assign ptr_next  = (ptr_ff == IDX_W'(CAPACITY - 1)) ? '0 : ptr_ff + 1'b1;
   assign head_next = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_in       = 1'b0;
      dup_in        = dup_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ma_res;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ptr_ff;

      case (state_ff)
         // take an item and pick its path
         IDLE: begin
            if (req_take) begin
               cmd_in         = req_cmd;
               key_in.pkt.src = req_source;
               key_in.pkt.dst = req_destination;
               key_in.pkt.ts  = req_timestamp;
               key_in.t_lo    = req_start_time;
               key_in.t_hi    = req_end_time;
               res_entry_in   = '0;
               res_status_in  = dpfrc_pkg::ST_EMPTY;
               ptr_in         = head_ff;
               idx_in         = '0;
               count_in       = '0;
               dup_in         = 1'b0;
               case (req_cmd)
                  dpfrc_pkg::CMD_ADD, dpfrc_pkg::CMD_COUNT: begin
                     state_in = SCAN;
                  end
                  dpfrc_pkg::CMD_FWD: begin
                     state_in = (fill_ff == '0) ? DONE : FETCH;
                  end
                  default: begin
                     state_in = DONE;
                  end
               endcase
            end
         end

         // walk the queue, one entry read and one compare per cycle
         SCAN: begin
            if (idx_ff != fill_ff) begin
               mem_rd_en = 1'b1;
               pend_in   = 1'b1;
               ptr_in    = ptr_next;
               idx_in    = idx_ff + 1'b1;
            end
            if (pend_ff) begin
               if (cmd_ff == dpfrc_pkg::CMD_ADD && hit.dup_hit) begin
                  dup_in = 1'b1;
               end
               if (cmd_ff == dpfrc_pkg::CMD_COUNT && hit.range_hit) begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (idx_ff == fill_ff && !pend_ff) begin
               if (cmd_ff == dpfrc_pkg::CMD_COUNT) begin
                  res_status_in = dpfrc_pkg::ST_COUNT;
                  state_in      = DONE;
               end else if (dup_ff) begin
                  res_status_in = dpfrc_pkg::ST_DUP;
                  state_in      = DONE;
               end else begin
                  state_in = DROP;
               end
            end
         end

         // drop the oldest entries that no longer fit under the limit
         DROP: begin
            if (fill_ext >= lim_eff) begin
               head_in = ma_res;
               fill_in = LEVEL_W'(lim_eff - 7'd1);
            end
            state_in = WRITE;
         end

         // append the new triple behind the newest entry
         WRITE: begin
            mem_wr_en     = 1'b1;
            fill_in       = fill_ff + 1'b1;
            res_status_in = dpfrc_pkg::ST_ADDED;
            state_in      = DONE;
         end

         // read the oldest entry
         FETCH: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = head_ff;
            state_in    = FDATA;
         end

         // pop the oldest entry
         FDATA: begin
            res_entry_in  = mem_rd_data;
            res_status_in = dpfrc_pkg::ST_FWD;
            head_in       = head_next;
            fill_in       = fill_ff - 1'b1;
            state_in      = DONE;
         end

         // hand the result to the output register once it is free
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_count_in  = dpfrc_pkg::COUNT_W'(count_ff);
               state_in      = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         limit_ff     <= dpfrc_pkg::LIMIT_RESET;
         head_ff      <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_out_source      = rsp_entry_ff.src;
   assign rsp_out_destination = rsp_entry_ff.dst;
   assign rsp_out_timestamp   = rsp_entry_ff.ts;
   assign rsp_match_count     = rsp_count_ff;

   // checks
   `DPFRC_ASSERT(a_fill_bound, clock, reset, fill_ff <= LEVEL_W'(LIM_MAX), "fill above limit")
   `DPFRC_ASSERT(a_head_bound, clock, reset, head_ff <= IDX_W'(CAPACITY - 1), "head out of range")
   `DPFRC_ASSERT(a_scan_bound, clock, reset, (state_ff == SCAN) |-> (idx_ff <= fill_ff), "scan overrun")
   `DPFRC_ASSERT(a_pop_level, clock, reset, (state_ff == FDATA) |=> (fill_ff == $past(fill_ff) - 1'b1), "pop did not lower fill")
   `DPFRC_ASSERT_ALWAYS(a_rsp_from_done, clock, (!reset && $rose(rsp_valid_ff)) |-> $past(state_ff == DONE), "result without finish")

endmodule
